// ----- rtl/core/imuwin_pkg.sv -----
// Shared types and constants for the IMU window averager with crash/fall detection.
// Holds the register map, configuration and controller/datapath command structs.
// No dependencies.
package imuwin_pkg;

   // Sample and accumulator widths
   localparam int SAMPLE_BITS = 16;
   localparam int IN_W        = 16;
   localparam int SUM_W       = 32;
   localparam int CNT_W       = 16;
   localparam int MEAN_W      = 17;
   localparam int DIFF_W      = MEAN_W + 1;
   localparam int REM_W       = CNT_W + 1;
   localparam int SQ_OP_W     = 17;
   localparam int SQ_W        = 2 * SQ_OP_W;
   localparam int SSQ_W       = SQ_W + 2;

   // Sequencer step counts
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQ_STEPS    = 5;
   localparam int STEP_W      = 5;
   localparam int SQ_IDX_W    = 3;

   // Lane indexes, also the squaring order of the accel lanes
   localparam int LANE_AX     = 0;
   localparam int LANE_AY     = 1;
   localparam int LANE_AZ     = 2;
   localparam int LANE_GZ     = 3;
   localparam int LANES       = 4;

   // Stream and register port widths
   localparam int REQ_DW      = 64;
   localparam int RSP_DW      = 72;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 16;

   localparam logic [15:0] CRASH_LIMIT_RESET = 16'd46000;
   localparam logic [15:0] FALL_LIMIT_RESET  = 16'd10000;

   // Register map
   typedef enum logic [CSR_AW-1:0] {
      REG_SAMPLE_COUNT   = 3'd0,
      REG_CALIB_ENABLE   = 3'd1,
      REG_OFFSET_ACCEL_X = 3'd2,
      REG_OFFSET_ACCEL_Y = 3'd3,
      REG_OFFSET_ACCEL_Z = 3'd4,
      REG_OFFSET_GYRO_Z  = 3'd5,
      REG_CRASH_LIMIT    = 3'd6,
      REG_FALL_LIMIT     = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [15:0]        sample_count;
      logic               calib_enable;
      logic signed [15:0] offset_accel_x;
      logic signed [15:0] offset_accel_y;
      logic signed [15:0] offset_accel_z;
      logic signed [15:0] offset_gyro_z;
      logic [15:0]        crash_limit;
      logic [15:0]        fall_limit;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic                accum;
      logic                close_load;
      logic                div_step;
      logic                mean_load;
      logic                sq_step;
      logic [SQ_IDX_W-1:0] sq_idx;
      logic                out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic close;
   } dp_status_type;

endpackage

// ----- rtl/core/imuwin_csr.sv -----
// Configuration registers of the IMU window averager.
// Plain write port, no read-back. Depends on imuwin_pkg.
module imuwin_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [imuwin_pkg::CSR_AW-1:0] csr_addr,
   input  logic [imuwin_pkg::CSR_DW-1:0] csr_wdata,
   output imuwin_pkg::cfg_type           cfg
);

   imuwin_pkg::cfg_type cfg_ff;
   imuwin_pkg::cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (imuwin_pkg::csr_reg_type'(csr_addr))
            imuwin_pkg::REG_SAMPLE_COUNT:   cfg_in.sample_count   = csr_wdata;
            imuwin_pkg::REG_CALIB_ENABLE:   cfg_in.calib_enable   = csr_wdata[0];
            imuwin_pkg::REG_OFFSET_ACCEL_X: cfg_in.offset_accel_x = csr_wdata;
            imuwin_pkg::REG_OFFSET_ACCEL_Y: cfg_in.offset_accel_y = csr_wdata;
            imuwin_pkg::REG_OFFSET_ACCEL_Z: cfg_in.offset_accel_z = csr_wdata;
            imuwin_pkg::REG_OFFSET_GYRO_Z:  cfg_in.offset_gyro_z  = csr_wdata;
            imuwin_pkg::REG_CRASH_LIMIT:    cfg_in.crash_limit    = csr_wdata;
            imuwin_pkg::REG_FALL_LIMIT:     cfg_in.fall_limit     = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count   <= 16'd1;
         cfg_ff.calib_enable   <= 1'b0;
         cfg_ff.offset_accel_x <= '0;
         cfg_ff.offset_accel_y <= '0;
         cfg_ff.offset_accel_z <= '0;
         cfg_ff.offset_gyro_z  <= '0;
         cfg_ff.crash_limit    <= imuwin_pkg::CRASH_LIMIT_RESET;
         cfg_ff.fall_limit     <= imuwin_pkg::FALL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/imuwin_ctrl.sv -----
// Sequencer of the IMU window averager: accept, divide, offset, square, deliver.
// Drives the datapath through dp_cmd_type. Depends on imuwin_pkg.
module imuwin_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  imuwin_pkg::dp_status_type status,
   output imuwin_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MEAN,
      ST_SQUARE,
      ST_DONE
   } state_type;

   state_type                         state_ff;
   logic [imuwin_pkg::STEP_W-1:0]     step_ff;
   logic                              rsp_valid_ff;

   // Commands decoded from the state
   always_comb begin
      cmd            = '0;
      cmd.accum      = req_tvalid && (state_ff == ST_IDLE);
      cmd.close_load = cmd.accum && status.close;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.mean_load  = (state_ff == ST_MEAN);
      cmd.sq_step    = (state_ff == ST_SQUARE);
      cmd.sq_idx     = step_ff[imuwin_pkg::SQ_IDX_W-1:0];
      cmd.out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   // State, step counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (cmd.close_load) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (step_ff == imuwin_pkg::STEP_W'(imuwin_pkg::DIV_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_MEAN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_MEAN: begin
               step_ff  <= '0;
               state_ff <= ST_SQUARE;
            end
            ST_SQUARE: begin
               if (step_ff == imuwin_pkg::STEP_W'(imuwin_pkg::SQ_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               step_ff  <= '0;
            end
         endcase

         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/core/imuwin_dp.sv -----
// Datapath of the IMU window averager: window sums, four bit-serial dividers,
// offset stage, shared squarer and the response register. Depends on imuwin_pkg.
module imuwin_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  imuwin_pkg::cfg_type                  cfg,
   input  imuwin_pkg::dp_cmd_type               cmd,
   output imuwin_pkg::dp_status_type            status,
   input  logic signed [imuwin_pkg::IN_W-1:0]   accel_x,
   input  logic signed [imuwin_pkg::IN_W-1:0]   accel_y,
   input  logic signed [imuwin_pkg::IN_W-1:0]   accel_z,
   input  logic signed [imuwin_pkg::IN_W-1:0]   gyro_z,
   output logic                                 crash,
   output logic                                 fall,
   output logic signed [imuwin_pkg::MEAN_W-1:0] mean_accel_x,
   output logic signed [imuwin_pkg::MEAN_W-1:0] mean_accel_y,
   output logic signed [imuwin_pkg::MEAN_W-1:0] mean_accel_z,
   output logic signed [imuwin_pkg::MEAN_W-1:0] mean_gyro_z
);

   localparam int SUM_W   = imuwin_pkg::SUM_W;
   localparam int CNT_W   = imuwin_pkg::CNT_W;
   localparam int REM_W   = imuwin_pkg::REM_W;
   localparam int MEAN_W  = imuwin_pkg::MEAN_W;
   localparam int DIFF_W  = imuwin_pkg::DIFF_W;
   localparam int SQ_OP_W = imuwin_pkg::SQ_OP_W;
   localparam int SQ_W    = imuwin_pkg::SQ_W;
   localparam int SSQ_W   = imuwin_pkg::SSQ_W;
   localparam int LANES   = imuwin_pkg::LANES;
   localparam int SB      = imuwin_pkg::SAMPLE_BITS;

   // Sign-extend the low SAMPLE_BITS of a raw sample to the sum width
   function automatic logic [SUM_W-1:0] sext_sample(input logic [imuwin_pkg::IN_W-1:0] raw);
      logic [SB-1:0] s;
      s = raw[SB-1:0];
      return {{(SUM_W-SB){s[SB-1]}}, s};
   endfunction

   function automatic logic [SQ_OP_W-1:0] abs_mean(input logic signed [MEAN_W-1:0] v);
      logic [MEAN_W-1:0] neg;
      neg = -v;
      return v[MEAN_W-1] ? neg : v;
   endfunction

   logic [SUM_W-1:0]   sum_ff [LANES];
   logic [SUM_W-1:0]   sum_nxt [LANES];
   logic [CNT_W-1:0]   taken_ff;
   logic [CNT_W:0]     n_full;
   logic [CNT_W-1:0]   need;

   logic [SUM_W-1:0]   dvd_ff [LANES];
   logic [REM_W-1:0]   rem_ff [LANES];
   logic               neg_ff [LANES];
   logic [CNT_W-1:0]   divisor_ff;

   logic signed [MEAN_W-1:0] mean_ff [LANES];
   logic signed [15:0]       offset [LANES];

   logic [SQ_OP_W-1:0] sq_op;
   logic [SQ_W-1:0]    prod_ff;
   logic [SSQ_W-1:0]   ssq_ff;
   logic [SQ_W-1:0]    lim_ff;

   logic                     rsp_crash_ff;
   logic                     rsp_fall_ff;
   logic signed [MEAN_W-1:0] rsp_mean_ff [LANES];

   // New sums with the incoming sample
   assign sum_nxt[imuwin_pkg::LANE_AX] = sum_ff[imuwin_pkg::LANE_AX] + sext_sample(accel_x);
   assign sum_nxt[imuwin_pkg::LANE_AY] = sum_ff[imuwin_pkg::LANE_AY] + sext_sample(accel_y);
   assign sum_nxt[imuwin_pkg::LANE_AZ] = sum_ff[imuwin_pkg::LANE_AZ] + sext_sample(accel_z);
   assign sum_nxt[imuwin_pkg::LANE_GZ] = sum_ff[imuwin_pkg::LANE_GZ] + sext_sample(gyro_z);

   assign offset[imuwin_pkg::LANE_AX] = cfg.offset_accel_x;
   assign offset[imuwin_pkg::LANE_AY] = cfg.offset_accel_y;
   assign offset[imuwin_pkg::LANE_AZ] = cfg.offset_accel_z;
   assign offset[imuwin_pkg::LANE_GZ] = cfg.offset_gyro_z;

   // Window close test; a zero count acts as one
   assign n_full       = {1'b0, taken_ff} + 1'b1;
   assign need         = (cfg.sample_count == '0) ? CNT_W'(1) : cfg.sample_count;
   assign status.close = (n_full >= {1'b0, need});

   // Window accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (cmd.accum) begin
         if (status.close) begin
            taken_ff <= '0;
            for (int i = 0; i < LANES; i++) begin
               sum_ff[i] <= '0;
            end
         end else begin
            taken_ff <= n_full[CNT_W-1:0];
            for (int i = 0; i < LANES; i++) begin
               sum_ff[i] <= sum_nxt[i];
            end
         end
      end
   end

   // Restoring dividers, one quotient bit per lane per cycle on magnitudes
   always_ff @(posedge clock) begin
      logic [REM_W-1:0] shifted;
      if (cmd.close_load) begin
         divisor_ff <= n_full[CNT_W-1:0];
         for (int i = 0; i < LANES; i++) begin
            neg_ff[i] <= sum_nxt[i][SUM_W-1];
            dvd_ff[i] <= sum_nxt[i][SUM_W-1] ? -sum_nxt[i] : sum_nxt[i];
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < LANES; i++) begin
            shifted = {rem_ff[i][REM_W-2:0], dvd_ff[i][SUM_W-1]};
            if (shifted >= {1'b0, divisor_ff}) begin
               rem_ff[i] <= shifted - {1'b0, divisor_ff};
               dvd_ff[i] <= {dvd_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= shifted;
               dvd_ff[i] <= {dvd_ff[i][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   // Signed means with optional offset removal
   always_ff @(posedge clock) begin
      logic [DIFF_W-1:0] q;
      logic [DIFF_W-1:0] m;
      if (cmd.mean_load) begin
         for (int i = 0; i < LANES; i++) begin
            q = {1'b0, dvd_ff[i][MEAN_W-1:0]};
            m = neg_ff[i] ? -q : q;
            if (cfg.calib_enable) begin
               m = m - {{(DIFF_W-16){offset[i][15]}}, offset[i]};
            end
            mean_ff[i] <= m[MEAN_W-1:0];
         end
      end
   end

   // Squarer operand: three accel means, then crash_limit + 1
   always_comb begin
      case (cmd.sq_idx)
         3'd0:    sq_op = abs_mean(mean_ff[imuwin_pkg::LANE_AX]);
         3'd1:    sq_op = abs_mean(mean_ff[imuwin_pkg::LANE_AY]);
         3'd2:    sq_op = abs_mean(mean_ff[imuwin_pkg::LANE_AZ]);
         3'd3:    sq_op = {1'b0, cfg.crash_limit} + 1'b1;
         default: sq_op = '0;
      endcase
   end

   // Registered product, summed one step later
   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         ssq_ff <= '0;
      end else if (cmd.sq_step) begin
         prod_ff <= sq_op * sq_op;
         case (cmd.sq_idx)
            3'd1, 3'd2, 3'd3: ssq_ff <= ssq_ff + {2'b00, prod_ff};
            3'd4:             lim_ff <= prod_ff;
            default:          ssq_ff <= ssq_ff;
         endcase
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_crash_ff <= (ssq_ff >= {2'b00, lim_ff});
         rsp_fall_ff  <= (abs_mean(mean_ff[imuwin_pkg::LANE_GZ]) > {1'b0, cfg.fall_limit});
         for (int i = 0; i < LANES; i++) begin
            rsp_mean_ff[i] <= mean_ff[i];
         end
      end
   end

   assign crash        = rsp_crash_ff;
   assign fall         = rsp_fall_ff;
   assign mean_accel_x = rsp_mean_ff[imuwin_pkg::LANE_AX];
   assign mean_accel_y = rsp_mean_ff[imuwin_pkg::LANE_AY];
   assign mean_accel_z = rsp_mean_ff[imuwin_pkg::LANE_AZ];
   assign mean_gyro_z  = rsp_mean_ff[imuwin_pkg::LANE_GZ];

endmodule

// ----- rtl/core/imu_window_average_crash_fall_detect_top.sv -----
// IMU window averager with crash and fall detection. Each request carries one
// accel x/y/z and gyro z sample; samples are summed until sample_count of them
// are in the window, and then one response gives the four truncated means
// (less the calibration offsets when calib_enable is set), crash when the
// integer magnitude of the accel mean exceeds crash_limit, and fall when
// |mean gyro z| exceeds fall_limit. A request that does not close the window
// is taken without stalling the request side. A closing request keeps
// req_tready low through the four parallel bit-serial dividers (one quotient
// bit each per cycle), the offset stage, the shared 17x17 squarer (three means
// and the limit) and the load of the response register, after which the next
// request can be taken. A held response delays that last step until rsp_tready
// frees the response register.
// Depends on imuwin_pkg, imuwin_csr, imuwin_ctrl and imuwin_dp.
module imu_window_average_crash_fall_detect_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_z[63:48]
   input  logic [imuwin_pkg::REQ_DW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // crash[0], fall[1], mean_accel_x[18:2], mean_accel_y[35:19],
   // mean_accel_z[52:36], mean_gyro_z[69:53], zero[71:70]
   output logic [imuwin_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [imuwin_pkg::CSR_AW-1:0] csr_addr,
   input  logic [imuwin_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int MEAN_W = imuwin_pkg::MEAN_W;

   imuwin_pkg::cfg_type       cfg;
   imuwin_pkg::dp_cmd_type    dp_cmd;
   imuwin_pkg::dp_status_type dp_status;

   logic                     crash;
   logic                     fall;
   logic signed [MEAN_W-1:0] mean_accel_x;
   logic signed [MEAN_W-1:0] mean_accel_y;
   logic signed [MEAN_W-1:0] mean_accel_z;
   logic signed [MEAN_W-1:0] mean_gyro_z;

   imuwin_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   imuwin_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   imuwin_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .accel_x      (req_tdata[15:0]),
      .accel_y      (req_tdata[31:16]),
      .accel_z      (req_tdata[47:32]),
      .gyro_z       (req_tdata[63:48]),
      .crash        (crash),
      .fall         (fall),
      .mean_accel_x (mean_accel_x),
      .mean_accel_y (mean_accel_y),
      .mean_accel_z (mean_accel_z),
      .mean_gyro_z  (mean_gyro_z)
   );

   // Response packing
   assign rsp_tdata = {2'b00, mean_gyro_z, mean_accel_z, mean_accel_y, mean_accel_x,
                       fall, crash};

   // A closing request stalls the request side for the window-end sequence
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && dp_status.close) |=> !req_tready)
      else $error("request side open right after a window closed");

   // The response register is never reloaded while a response is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending response overwritten");

   // A response appears only after a load of the response register
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(dp_cmd.out_load))
      else $error("response valid without a load");

endmodule
